// ===== design/mkc_pkg.sv =====
// mkc_pkg: shared types and constants of the multi-key click event detector
// request structs, flag bit positions, phase codes, register indexes
// no dependencies
package mkc_pkg;

    localparam int FLAG_W     = 7;
    localparam int TIMER_W    = 16;
    localparam int DIV_W      = 4;
    localparam int LEVEL_BITS = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // flag bit positions
    localparam int FLAG_HOLD   = 0;
    localparam int FLAG_DOWN   = 1;
    localparam int FLAG_UP     = 2;
    localparam int FLAG_SINGLE = 3;
    localparam int FLAG_DOUBLE = 4;
    localparam int FLAG_LONG   = 5;
    localparam int FLAG_REPEAT = 6;

    localparam logic [FLAG_W-1:0] MASK_HOLD_ONLY = 7'b000_0001;

    // request modes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DIV  = 2'd3;

    // per-key click phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRESSED = 3'd1,
        PH_WAIT    = 3'd2,
        PH_SECOND  = 3'd3,
        PH_LONG    = 3'd4
    } phase_t;

    typedef struct packed {
        logic                  mode;
        logic [LEVEL_BITS-1:0] key_levels;
        logic [1:0]            key_index;
        logic [FLAG_W-1:0]     flag_mask;
    } item_t;

    typedef struct packed {
        logic              hit;
        logic [FLAG_W-1:0] flags_before;
    } result_t;

    typedef struct packed {
        logic [TIMER_W-1:0] long_press_ticks;
        logic [TIMER_W-1:0] double_gap_ticks;
        logic [TIMER_W-1:0] repeat_ticks;
    } timeouts_t;

    // per-key control from the top level
    typedef struct packed {
        logic              tick;
        logic              sample;
        logic              pressed;
        logic              clear;
        logic [FLAG_W-1:0] clear_mask;
    } key_ctl_t;

endpackage

// ===== design/mkc_key_unit.sv =====
// mkc_key_unit: state of one key (level, phase, timer, flags) and its update
// for a tick, a sample or a flag clear
// depends on mkc_pkg
module mkc_key_unit
    import mkc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  key_ctl_t          ctl,
    input  timeouts_t         timeouts,
    output logic [FLAG_W-1:0] flags
);

    logic               level_reg;
    logic               level_next;
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timer_next;
    logic [TIMER_W-1:0] timer_dec;
    logic [FLAG_W-1:0]  flags_reg;
    logic [FLAG_W-1:0]  flags_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            flags_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            flags_reg <= flags_next;
        end
    end

    // timer counts down to zero on every tick
    assign timer_dec = (timer_reg != '0) ? timer_reg - TIMER_W'(1) : timer_reg;

    // next state: tick with optional sample, or flag clear on a check
    always_comb
    begin
        level_next = level_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        flags_next = flags_reg;
        if (ctl.tick)
        begin
            timer_next = timer_dec;
            if (ctl.sample)
            begin
                level_next = ctl.pressed;
                flags_next[FLAG_HOLD] = ctl.pressed;
                if (ctl.pressed && !level_reg)
                    flags_next[FLAG_DOWN] = 1'b1;
                if (!ctl.pressed && level_reg)
                    flags_next[FLAG_UP] = 1'b1;
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (ctl.pressed)
                        begin
                            timer_next = timeouts.long_press_ticks;
                            phase_next = PH_PRESSED;
                        end
                    end
                    PH_PRESSED:
                    begin
                        if (!ctl.pressed)
                        begin
                            timer_next = timeouts.double_gap_ticks;
                            phase_next = PH_WAIT;
                        end
                        else if (timer_dec == '0)
                        begin
                            timer_next = timeouts.repeat_ticks;
                            flags_next[FLAG_LONG] = 1'b1;
                            phase_next = PH_LONG;
                        end
                    end
                    PH_WAIT:
                    begin
                        if (ctl.pressed)
                        begin
                            flags_next[FLAG_DOUBLE] = 1'b1;
                            phase_next = PH_SECOND;
                        end
                        else if (timer_dec == '0)
                        begin
                            flags_next[FLAG_SINGLE] = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_SECOND:
                    begin
                        if (!ctl.pressed)
                            phase_next = PH_IDLE;
                    end
                    PH_LONG:
                    begin
                        if (!ctl.pressed)
                            phase_next = PH_IDLE;
                        else if (timer_dec == '0)
                        begin
                            timer_next = timeouts.repeat_ticks;
                            flags_next[FLAG_REPEAT] = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        else if (ctl.clear)
        begin
            flags_next = flags_reg & ~ctl.clear_mask;
        end
    end

    assign flags = flags_reg;

endmodule

// ===== design/multi_key_click_event_detector.sv =====
// An accepted request is held in the input register and then moves to the result register,
// from which its result can be taken; one request per cycle is taken while result_stall is low.
// The state update of every key runs in the cycle a request moves from the input
// register to the result register, so back-to-back requests see each other's effects.
// Reset (rst_n low, asynchronous) empties both registers, clears all key state and
// loads the timeout registers with 100, 20, 100 and the sample divider with 3.
module multi_key_click_event_detector
    import mkc_pkg::*;
#(
    parameter int NUM_KEYS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    timeouts_t          timeouts_reg;
    logic [DIV_W-1:0]   sample_divide_reg;
    logic [DIV_W-1:0]   divider_reg;
    logic [DIV_W-1:0]   divider_next;
    logic [DIV_W-1:0]   divider_inc;
    logic               sample;

    logic               in_valid_reg;
    item_t              in_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            out_next;

    logic               accept;
    logic               process;
    logic               is_tick;
    logic               is_check;
    logic               hit;
    logic [FLAG_W-1:0]  before_sel;

    logic [NUM_KEYS-1:0] key_sel;
    logic [NUM_KEYS-1:0] pin_active;
    logic [FLAG_W-1:0]   key_flags [NUM_KEYS];

    // handshake: input register moves on when the result register is free or taken
    assign process    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !process;
    assign accept     = item_valid && !item_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeouts_reg.long_press_ticks <= TIMER_W'(100);
            timeouts_reg.double_gap_ticks <= TIMER_W'(20);
            timeouts_reg.repeat_ticks     <= TIMER_W'(100);
            sample_divide_reg             <= DIV_W'(3);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS: timeouts_reg.long_press_ticks <= cfg_data;
                REG_DOUBLE_GAP: timeouts_reg.double_gap_ticks <= cfg_data;
                REG_REPEAT:     timeouts_reg.repeat_ticks     <= cfg_data;
                REG_SAMPLE_DIV: sample_divide_reg             <= cfg_data[DIV_W-1:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (process)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= item;
    end

    assign is_tick  = process && (in_reg.mode == MODE_TICK);
    assign is_check = in_reg.mode == MODE_CHECK;

    // sample divider
    assign divider_inc  = divider_reg + DIV_W'(1);
    assign sample       = divider_inc >= sample_divide_reg;
    assign divider_next = sample ? '0 : divider_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            divider_reg <= '0;
        else if (is_tick)
            divider_reg <= divider_next;
    end

    // per-key units
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        key_ctl_t ctl;

        if (k < LEVEL_BITS)
        begin : g_pin
            assign pin_active[k] = ~in_reg.key_levels[k];
        end
        else
        begin : g_nopin
            assign pin_active[k] = 1'b0;
        end

        assign key_sel[k] = 32'(in_reg.key_index) == k;

        always_comb
        begin
            ctl.tick       = is_tick;
            ctl.sample     = sample;
            ctl.pressed    = pin_active[k];
            ctl.clear      = process && is_check && key_sel[k] && hit
                             && (in_reg.flag_mask != MASK_HOLD_ONLY);
            ctl.clear_mask = in_reg.flag_mask;
        end

        mkc_key_unit u_key
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .timeouts (timeouts_reg),
            .flags    (key_flags[k])
        );
    end

    // selected key's flags, zero when the index names no key
    always_comb
    begin
        before_sel = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (key_sel[k])
                before_sel = key_flags[k];
        end
    end

    assign hit = is_check && ((before_sel & in_reg.flag_mask) != '0);

    always_comb
    begin
        out_next.hit          = hit;
        out_next.flags_before = before_sel;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (process)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (process)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== design/mkc_checker.sv =====
// mkc_checker: port-level assertions for the click event detector, bound to the top
// depends on mkc_pkg and multi_key_click_event_detector
module mkc_checker
    import mkc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // a hit always shows some flag set before the request
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.hit |-> result.flags_before != '0)
        else $error("hit reported with no flag set");

    // an accepted request reaches the output once the output side is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) ##1 !result_stall |=> result_valid)
        else $error("accepted request did not produce a result");

    // an empty output register never holds off the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled while output empty");

    // nothing comes out right after reset
    assert property (@(posedge clk)
        $past(!rst_n) |-> !result_valid)
        else $error("result valid after reset");

endmodule

bind multi_key_click_event_detector mkc_checker u_mkc_checker (.*);
